// File: design/lwphs_pkg.sv
// shared types and constants for the line walk pixel hit search block
`default_nettype none

package lwphs_pkg;

   localparam int MAX_SIDE_DEFAULT = 64;
   localparam int COORD_W          = 12;
   localparam int DELTA_W          = 12;
   localparam int ERR_W            = 15;
   localparam int DIM_W            = 7;
   localparam int HIT_W            = 6;
   localparam int CSR_INDEX_W      = 2;
   localparam int LIM_W            = COORD_W - 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TRACE = 1'b1;

   typedef struct packed {
      logic                      opcode;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic                      stop_on_opaque;
      logic                      pixel_opaque;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [HIT_W-1:0] hit_x;
      logic [HIT_W-1:0] hit_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } walk_pos_type;

endpackage

`default_nettype wire

// File: design/lwphs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lwphs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/lwphs_walker.sv
// bresenham step unit holding the current point of a trace
`default_nettype none

module lwphs_walker (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic                  advance,
   input  wire lwphs_pkg::req_type    req,
   output      lwphs_pkg::walk_pos_type pos
);

   import lwphs_pkg::*;

   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [COORD_W-1:0] ex_ff, ey_ff;
   logic        [DELTA_W-1:0] dx_ff, dy_ff;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      x_neg_ff, y_neg_ff;

   logic signed [COORD_W:0]   diff_x, diff_y;
   logic        [DELTA_W-1:0] dx_load, dy_load;
   logic signed [ERR_W:0]     e2, dx_ext, dy_ext;
   logic                      step_x, step_y;

   always_comb begin
      diff_x  = {req.end_x[COORD_W-1], req.end_x} - {req.start_x[COORD_W-1], req.start_x};
      diff_y  = {req.end_y[COORD_W-1], req.end_y} - {req.start_y[COORD_W-1], req.start_y};
      dx_load = diff_x[COORD_W] ? DELTA_W'(-diff_x) : diff_x[DELTA_W-1:0];
      dy_load = diff_y[COORD_W] ? DELTA_W'(-diff_y) : diff_y[DELTA_W-1:0];

      e2     = {err_ff, 1'b0};
      dx_ext = $signed({{(ERR_W+1-DELTA_W){1'b0}}, dx_ff});
      dy_ext = $signed({{(ERR_W+1-DELTA_W){1'b0}}, dy_ff});
      step_x = e2 > -dy_ext;
      step_y = e2 < dx_ext;

      x_in   = x_ff;
      y_in   = y_ff;
      err_in = err_ff;
      if (load) begin
         x_in   = req.start_x;
         y_in   = req.start_y;
         err_in = $signed(ERR_W'(dx_load)) - $signed(ERR_W'(dy_load));
      end else if (advance) begin
         err_in = ERR_W'(err_ff - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0));
         if (step_x) begin
            x_in = x_neg_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
         end
         if (step_y) begin
            y_in = y_neg_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      err_ff <= err_in;
      if (load) begin
         ex_ff    <= req.end_x;
         ey_ff    <= req.end_y;
         dx_ff    <= dx_load;
         dy_ff    <= dy_load;
         x_neg_ff <= !(req.start_x < req.end_x);
         y_neg_ff <= !(req.start_y < req.end_y);
      end
   end

   assign pos.x    = x_ff;
   assign pos.y    = y_ff;
   assign pos.last = (x_ff == ex_ff) && (y_ff == ey_ff);

endmodule

`default_nettype wire

// File: design/line_walk_pixel_hit_search.sv
// top level of the line walk pixel hit search block
`default_nettype none

// Holds a one-bit opacity map of MAX_SIDE x MAX_SIDE pixels, one map row per
// ram word. A request beat is taken when start is high and busy is low.
// A write request sets one pixel by reading its row, changing the bit and
// writing the row back: busy stays high in ST_WR_READ and ST_WR_WRITE after
// the beat, and no response is given, so a new write is taken only when
// the last row is written back. A write outside the map is dropped at once.
// A trace request walks the bresenham line from start to end, one pixel a
// cycle through the row read port, and tests the pixels inside the image
// size set over the csr port. The response beat (rsp_valid for one cycle)
// is registered after the test of the hit pixel, or of the end point when
// no pixel hits; the walk covers at most max(|dx|,|dy|) + 1 = 4096 pixels.
// The receiver cannot stall: the response is shown once and busy falls
// with it, so the next request can be taken at the edge that takes the
// response.
// After reset the map is cleared one row a cycle, with busy high until
// every row is cleared; csr writes are taken at any time.
module line_walk_pixel_hit_search #(
   parameter int MAX_SIDE = lwphs_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire lwphs_pkg::req_type                req_data,
   output      logic                              rsp_valid,
   output      lwphs_pkg::rsp_type                rsp_data,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [lwphs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lwphs_pkg::DIM_W-1:0]       csr_data
);

   import lwphs_pkg::*;

   localparam int AW = $clog2(MAX_SIDE);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_TRACE
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [AW-1:0]    clear_cnt_ff, clear_cnt_in;
   logic [AW-1:0]    wr_row_ff, wr_row_in, wr_col_ff, wr_col_in;
   logic             wr_val_ff, wr_val_in;
   logic             want_ff, want_in;
   logic             issuing_ff, issuing_in;
   logic             b_valid_ff, b_valid_in;
   logic             b_inb_ff, b_inb_in;
   logic             b_last_ff, b_last_in;
   logic [AW-1:0]    b_col_ff, b_col_in;
   logic [HIT_W-1:0] b_x_ff, b_x_in, b_y_ff, b_y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [MAX_SIDE-1:0] mem_wr_data, mem_rd_data;

   logic         walk_load, walk_adv;
   walk_pos_type pos;

   logic [LIM_W-1:0] wlim, hlim;
   logic             pos_inb, wr_inb, hit;

   lwphs_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lwphs_walker u_walker (
      .clock   (clock),
      .load    (walk_load),
      .advance (walk_adv),
      .req     (req_data),
      .pos     (pos)
   );

   always_comb begin
      wlim = (LIM_W'(width_ff) > LIM_W'(MAX_SIDE)) ? LIM_W'(MAX_SIDE) : LIM_W'(width_ff);
      hlim = (LIM_W'(height_ff) > LIM_W'(MAX_SIDE)) ? LIM_W'(MAX_SIDE) : LIM_W'(height_ff);
      pos_inb = !pos.x[COORD_W-1] && !pos.y[COORD_W-1]
             && (pos.x[LIM_W-1:0] < wlim) && (pos.y[LIM_W-1:0] < hlim);
      wr_inb = !req_data.start_x[COORD_W-1] && !req_data.start_y[COORD_W-1]
            && (req_data.start_x[LIM_W-1:0] < LIM_W'(MAX_SIDE))
            && (req_data.start_y[LIM_W-1:0] < LIM_W'(MAX_SIDE));
      hit = b_inb_ff && (mem_rd_data[b_col_ff] == want_ff);
   end

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      clear_cnt_in = clear_cnt_ff;
      wr_row_in    = wr_row_ff;
      wr_col_in    = wr_col_ff;
      wr_val_in    = wr_val_ff;
      want_in      = want_ff;
      issuing_in   = 1'b0;
      b_valid_in   = 1'b0;
      b_inb_in     = pos_inb;
      b_last_in    = pos.last;
      b_col_in     = pos.x[AW-1:0];
      b_x_in       = pos.x[HIT_W-1:0];
      b_y_in       = pos.y[HIT_W-1:0];
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_row_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = wr_row_ff;
      walk_load    = 1'b0;
      walk_adv     = 1'b0;

      if (csr_valid && csr_index == CSR_IMAGE_WIDTH) begin
         width_in = csr_data;
      end
      if (csr_valid && csr_index == CSR_IMAGE_HEIGHT) begin
         height_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = clear_cnt_ff;
            mem_wr_data  = '0;
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == AW'(MAX_SIDE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.opcode == OP_TRACE) begin
                  walk_load  = 1'b1;
                  issuing_in = 1'b1;
                  want_in    = req_data.stop_on_opaque;
                  state_in   = ST_TRACE;
               end else if (wr_inb) begin
                  wr_row_in = req_data.start_y[AW-1:0];
                  wr_col_in = req_data.start_x[AW-1:0];
                  wr_val_in = req_data.pixel_opaque;
                  state_in  = ST_WR_READ;
               end
            end
         end
         ST_WR_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_WR_WRITE;
         end
         ST_WR_WRITE: begin
            mem_wr_en              = 1'b1;
            mem_wr_data[wr_col_ff] = wr_val_ff;
            state_in               = ST_IDLE;
         end
         ST_TRACE: begin
            mem_rd_en   = issuing_ff;
            mem_rd_addr = pos.y[AW-1:0];
            b_valid_in  = issuing_ff;
            walk_adv    = issuing_ff && !pos.last;
            issuing_in  = issuing_ff && !pos.last;
            if (b_valid_ff && (hit || b_last_ff)) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.found = hit;
               rsp_data_in.hit_x = hit ? b_x_ff : '0;
               rsp_data_in.hit_y = hit ? b_y_ff : '0;
               issuing_in        = 1'b0;
               b_valid_in        = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         clear_cnt_ff <= '0;
         issuing_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         clear_cnt_ff <= clear_cnt_in;
         issuing_ff   <= issuing_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wr_row_ff   <= wr_row_in;
      wr_col_ff   <= wr_col_in;
      wr_val_ff   <= wr_val_in;
      want_ff     <= want_in;
      b_inb_ff    <= b_inb_in;
      b_last_ff   <= b_last_in;
      b_col_ff    <= b_col_in;
      b_x_ff      <= b_x_in;
      b_y_ff      <= b_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a response only closes a trace
   a_rsp_after_trace: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_TRACE))
      else $error("response without a trace");

   // the walk never tests past the end point
   a_stop_at_last: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_last_ff) |=> !b_valid_ff)
      else $error("pixel tested beyond line end");

   // a miss reports a zero position
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
         (rsp_data_ff.hit_x == '0 && rsp_data_ff.hit_y == '0))
      else $error("miss with nonzero position");

   // the map is never written during a trace
   a_no_write_in_trace: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRACE) |-> !mem_wr_en)
      else $error("map written during trace");

endmodule

`default_nettype wire
